// ===== rtl/core/atn_pkg.sv =====
`timescale 1ns / 1ps
package atn_pkg;

    // Character codes
    localparam logic [7:0] ChSpace    = 8'h20;
    localparam logic [7:0] ChTab      = 8'h09;
    localparam logic [7:0] ChLf       = 8'h0A;
    localparam logic [7:0] ChCr       = 8'h0D;
    localparam logic [7:0] ChFf       = 8'h0C;
    localparam logic [7:0] ChTilde    = 8'h7E;
    localparam logic [7:0] ChQuestion = 8'h3F;
    localparam logic [7:0] ChUpperA   = 8'h41;
    localparam logic [7:0] ChUpperZ   = 8'h5A;
    localparam logic [7:0] CaseOffset = 8'h20;

    localparam int unsigned LenW        = 16;
    localparam logic [LenW-1:0] CapReset = 16'hFFFF;

    // Result queue
    localparam int unsigned QDepth = 8;
    localparam int unsigned QPtrW  = $clog2(QDepth);
    localparam int unsigned QCntW  = $clog2(QDepth + 1);

    // One result word
    typedef struct packed {
        logic            eot;
        logic [LenW-1:0] len;
        logic            valid;
        logic [6:0]      ch;
    } t_result;

    // Results produced by one item, handed to the queue
    typedef struct packed {
        logic [1:0] cnt;
        t_result    res0;
        t_result    res1;
    } t_push;

    function automatic logic is_white(input logic [7:0] b);
        return (b == ChSpace) || (b == ChTab) || (b == ChLf) ||
               (b == ChCr) || (b == ChFf);
    endfunction

    // Map a visible byte to its normalized character
    function automatic logic [6:0] norm_char(input logic [7:0] b);
        logic [7:0] c;
        c = (b > ChTilde) ? ChQuestion : b;
        if ((c >= ChUpperA) && (c <= ChUpperZ)) begin
            c = c + CaseOffset;
        end
        return c[6:0];
    endfunction

endpackage

// ===== rtl/core/ascii_text_normalizer.sv =====
// An accepted word lands in the input register; its result words then enter the result queue.
// Throughput: one input word per cycle; a character that releases a held space yields
//   two result words, drained at one per cycle while m_axis_tready is high, via an eight-entry queue.
// Input stalls only when that queue may lack room for two words per item in flight.
// Reset (i_rst_n, synchronous, active low): capacity returns to 65535, text state
//   and queue clear.
`timescale 1ns / 1ps
module ascii_text_normalizer (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Configuration: out_capacity
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [atn_pkg::LenW-1:0]  i_cfg_wdata,
    // Input stream
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [7:0]                s_axis_tdata,   // [7:0] in_byte
    input  logic                      s_axis_tlast,   // is_last
    // Output stream
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [23:0]               m_axis_tdata,   // [6:0] out_char, [22:7] final_length, [23] 0
    output logic                      m_axis_tuser,   // char_valid
    output logic                      m_axis_tlast    // end_of_text
);
    import atn_pkg::*;

    logic [LenW-1:0]   r_capacity;
    logic              accept;
    logic              busy;
    t_push             push;
    t_result           head;
    logic [QCntW-1:0]  q_count;
    logic [QCntW+1:0]  q_need;

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CapReset;
        end else if (i_cfg_valid) begin
            r_capacity <= i_cfg_wdata;
        end
    end
    assign o_cfg_ready = 1'b1;

    // Room for the item in the input register plus the one now offered
    assign q_need = (QCntW + 2)'(q_count) + (busy ? (QCntW + 2)'(2) : '0)
                    + (QCntW + 2)'(2);
    assign s_axis_tready = q_need <= (QCntW + 2)'(QDepth);
    assign accept        = s_axis_tvalid && s_axis_tready;

    atn_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_byte     (s_axis_tdata),
        .i_last     (s_axis_tlast),
        .i_capacity (r_capacity),
        .o_busy     (busy),
        .o_push     (push)
    );

    atn_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_head  (head),
        .o_count (q_count)
    );

    assign m_axis_tdata = {1'b0, head.len, head.ch};
    assign m_axis_tuser = head.valid;
    assign m_axis_tlast = head.eot;

endmodule

// ===== rtl/core/atn_core.sv =====
`timescale 1ns / 1ps
module atn_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  logic [7:0]                i_byte,
    input  logic                      i_last,
    input  logic [atn_pkg::LenW-1:0]  i_capacity,
    output logic                      o_busy,
    output atn_pkg::t_push            o_push
);
    import atn_pkg::*;

    // Input register
    logic            r_in_valid;
    logic [7:0]      r_in_byte;
    logic            r_in_last;

    // Text state
    logic [LenW-1:0] r_written_count, n_written_count;
    logic            r_prev_space, n_prev_space;
    logic            r_seen_visible, n_seen_visible;
    logic            r_held_space, n_held_space;

    logic            white;
    logic            ctrl;
    logic            room;
    logic [6:0]      ch;
    logic [LenW:0]   count_inc;
    t_result         res_space;
    t_result         res_char;
    t_result         res_empty;
    t_push           push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_accept;
        end
        if (i_accept) begin
            r_in_byte <= i_byte;
            r_in_last <= i_last;
        end
    end

    assign white     = is_white(r_in_byte);
    assign ctrl      = r_in_byte < ChSpace;
    assign count_inc = {1'b0, r_written_count} + {{LenW{1'b0}}, 1'b1};
    assign room      = count_inc < {1'b0, i_capacity};
    assign ch        = norm_char(r_in_byte);

    always_comb begin
        res_space       = '0;
        res_space.valid = 1'b1;
        res_space.ch    = ChSpace[6:0];
        res_char        = '0;
        res_char.valid  = 1'b1;
        res_char.ch     = ch;
        res_empty       = '0;
    end

    // Per-item normalization and result build
    always_comb begin
        n_written_count = r_written_count;
        n_prev_space    = r_prev_space;
        n_seen_visible  = r_seen_visible;
        n_held_space    = r_held_space;
        push            = '0;
        if (r_in_valid) begin
            if (white) begin
                if (!r_prev_space && r_seen_visible) begin
                    if (room) begin
                        n_held_space    = 1'b1;
                        n_written_count = count_inc[LenW-1:0];
                    end
                    n_prev_space = 1'b1;
                end
            end else if (!ctrl) begin
                if (room) begin
                    if (r_held_space) begin
                        push.res0    = res_space;
                        push.res1    = res_char;
                        push.cnt     = 2'd2;
                        n_held_space = 1'b0;
                    end else begin
                        push.res0 = res_char;
                        push.cnt  = 2'd1;
                    end
                    n_written_count = count_inc[LenW-1:0];
                end
                n_prev_space   = 1'b0;
                n_seen_visible = 1'b1;
            end

            // End of text: tag the final word (or push an empty one), then start over
            if (r_in_last) begin
                unique case (push.cnt)
                    2'd2: begin
                        push.res1.eot = 1'b1;
                        push.res1.len = n_written_count - {{(LenW-1){1'b0}}, n_held_space};
                    end
                    2'd1: begin
                        push.res0.eot = 1'b1;
                        push.res0.len = n_written_count - {{(LenW-1){1'b0}}, n_held_space};
                    end
                    default: begin
                        push.res0     = res_empty;
                        push.res0.eot = 1'b1;
                        push.res0.len = n_written_count - {{(LenW-1){1'b0}}, n_held_space};
                        push.cnt      = 2'd1;
                    end
                endcase
                n_written_count = '0;
                n_prev_space    = 1'b0;
                n_seen_visible  = 1'b0;
                n_held_space    = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written_count <= '0;
            r_prev_space    <= 1'b0;
            r_seen_visible  <= 1'b0;
            r_held_space    <= 1'b0;
        end else begin
            r_written_count <= n_written_count;
            r_prev_space    <= n_prev_space;
            r_seen_visible  <= n_seen_visible;
            r_held_space    <= n_held_space;
        end
    end

    assign o_busy = r_in_valid;
    assign o_push = push;

    // A last byte always leaves the text state cleared
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_last) |=>
            (r_written_count == '0) && !r_held_space && !r_seen_visible)
        else $error("text state not cleared after last byte");

    // Two words only when a held space is released ahead of a character
    a_pair_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.cnt == 2'd2) |-> (push.res0.ch == ChSpace[6:0]) && r_held_space)
        else $error("word pair without held space");

    // Every last byte yields at least one word carrying end of text
    a_last_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_last) |-> (push.cnt != 2'd0) &&
            (push.res0.eot || push.res1.eot))
        else $error("last byte without end-of-text word");

endmodule

// ===== rtl/core/atn_out_queue.sv =====
`timescale 1ns / 1ps
module atn_out_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  atn_pkg::t_push             i_push,
    input  logic                       i_pop,
    output logic                       o_valid,
    output atn_pkg::t_result           o_head,
    output logic [atn_pkg::QCntW-1:0]  o_count
);
    import atn_pkg::*;

    t_result           r_mem [QDepth];
    logic [QPtrW-1:0]  r_wptr, r_rptr;
    logic [QCntW-1:0]  r_count;
    logic [QPtrW-1:0]  wptr_1;
    logic              do_pop;

    assign wptr_1 = r_wptr + QPtrW'(1);
    assign do_pop = i_pop && (r_count != '0);

    // Storage: up to two words written per cycle
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wptr] <= i_push.res0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wptr_1] <= i_push.res1;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + QPtrW'(i_push.cnt);
            r_rptr  <= r_rptr + QPtrW'(do_pop);
            r_count <= r_count + QCntW'(i_push.cnt) - QCntW'(do_pop);
        end
    end

    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rptr];
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (QCntW + 1)'(r_count) + (QCntW + 1)'(i_push.cnt) <= (QCntW + 1)'(QDepth))
        else $error("result queue overflow");

    a_count_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == QCntW'(QDepth)) |-> (r_wptr == r_rptr))
        else $error("queue pointers disagree with count");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_count == $past(r_count) + QCntW'($past(i_push.cnt))
                  - QCntW'($past(do_pop))))
        else $error("queue count step wrong");

endmodule

// ===== dv/ascii_text_normalizer_tb.sv =====
`timescale 1ns / 1ps
module ascii_text_normalizer_tb;
    import atn_pkg::*;

    localparam int unsigned WatchdogLimit = 2000;
    localparam int unsigned RandomItems   = 1450;
    localparam int unsigned DrainCycles   = 8;
    localparam int unsigned MaxPrints     = 40;

    // Receiver stall patterns
    typedef enum int {
        ReadyAlways,
        ReadyRandom,
        ReadyPattern,
        ReadySparse
    } t_ready_mode;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_valid   = 1'b0;
    logic              o_cfg_ready;
    logic [LenW-1:0]   i_cfg_wdata   = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata  = '0;
    logic              s_axis_tlast  = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [23:0]       m_axis_tdata;
    logic              m_axis_tuser;
    logic              m_axis_tlast;

    // Shadow of the normalizer state and its capacity register
    logic [LenW-1:0]   capacity_shadow = CapReset;
    int unsigned       chars_written   = 0;
    bit                in_space_run    = 1'b0;
    bit                seen_visible    = 1'b0;
    bit                space_pending   = 1'b0;
    t_result           pending_words[$];

    int unsigned       mismatch_count = 0;
    int unsigned       idle_cycles    = 0;
    int unsigned       items_sent     = 0;
    int unsigned       burst_left     = 0;
    int unsigned       gap_max        = 0;
    t_ready_mode       ready_mode     = ReadyAlways;
    logic [3:0]        ready_phase    = '0;

    always #2 i_clk = ~i_clk;

    ascii_text_normalizer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    task automatic report_mismatch(input string what, input int unsigned want_v,
                                   input int unsigned got_v);
        mismatch_count++;
        if (mismatch_count <= MaxPrints) begin
            $display("mismatch %s: expected 0x%0h got 0x%0h at %0t",
                     what, want_v, got_v, $time);
        end
    endtask

    // Works out the result words one input byte causes and queues them
    task automatic normalize_byte(input logic [7:0] in_b, input logic end_mark);
        t_result    words [2];
        int         n;
        logic [7:0] c;
        bit         white;
        bit         room;
        white = (in_b == ChSpace) || (in_b == ChTab) || (in_b == ChLf) ||
                (in_b == ChCr) || (in_b == ChFf);
        room = (chars_written + 1) < capacity_shadow;
        n = 0;
        words[0] = '0;
        words[1] = '0;
        if (white) begin
            // first blank after visible text is written but held back
            if (!in_space_run && seen_visible) begin
                if (room) begin
                    space_pending = 1'b1;
                    chars_written++;
                end
                in_space_run = 1'b1;
            end
        end else if (in_b >= ChSpace) begin
            c = (in_b > ChTilde) ? ChQuestion : in_b;
            if ((c >= ChUpperA) && (c <= ChUpperZ)) begin
                c = c + CaseOffset;
            end
            if (room) begin
                if (space_pending) begin
                    words[n].ch    = ChSpace[6:0];
                    words[n].valid = 1'b1;
                    n++;
                    space_pending = 1'b0;
                end
                words[n].ch    = c[6:0];
                words[n].valid = 1'b1;
                n++;
                chars_written++;
            end
            in_space_run = 1'b0;
            seen_visible = 1'b1;
        end
        // end of text: tag last word (or an empty one), drop held space
        if (end_mark) begin
            if (n == 0) begin
                n = 1;
            end
            words[n-1].eot = 1'b1;
            words[n-1].len = LenW'(chars_written - space_pending);
            chars_written = 0;
            in_space_run  = 1'b0;
            seen_visible  = 1'b0;
            space_pending = 1'b0;
        end
        for (int k = 0; k < n; k++) begin
            pending_words.push_back(words[k]);
        end
    endtask

    // Sends one word, then maybe ends the burst with a random gap
    task automatic send_byte(input logic [7:0] in_b, input logic end_mark);
        int unsigned gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= in_b;
        s_axis_tlast  <= end_mark;
        do @(posedge i_clk); while (!s_axis_tready);
        normalize_byte(in_b, end_mark);
        items_sent++;
        if (burst_left == 0) begin
            gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 1);
            burst_left = $urandom_range(24, 1);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_text(input string s, input bit end_mark);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], end_mark && (i == s.len() - 1));
        end
    endtask

    // Stop sending and let every pending word come out
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [LenW-1:0] value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_wdata <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        capacity_shadow = value;
    endtask

    function automatic logic [7:0] text_byte();
        int unsigned r;
        logic [7:0]  b;
        r = $urandom_range(19, 0);
        if (r < 9) begin
            b = $urandom_range(1, 0) ? 8'($urandom_range(8'h7A, 8'h61))
                                     : 8'($urandom_range(ChUpperZ, ChUpperA));
        end else if (r < 13) begin
            case ($urandom_range(4, 0))
                0:       b = ChSpace;
                1:       b = ChTab;
                2:       b = ChLf;
                3:       b = ChCr;
                default: b = ChFf;
            endcase
        end else if (r < 15) begin
            b = 8'($urandom_range(ChTilde, ChSpace + 1));
        end else if (r < 17) begin
            b = 8'($urandom_range(ChSpace - 1, 0));
        end else if (r < 18) begin
            b = 8'($urandom_range(8'hFF, ChTilde + 1));
        end else begin
            b = 8'($urandom_range(8'hFF, 0));
        end
        return b;
    endfunction

    // Mostly small buffers so the full condition is hit often
    function automatic logic [LenW-1:0] pick_capacity();
        logic [LenW-1:0] v;
        case ($urandom_range(7, 0))
            0:       v = '0;
            1:       v = CapReset;
            2:       v = CapReset - 1'b1;
            3:       v = LenW'($urandom_range(16'hFFFF, 0));
            4, 5:    v = LenW'($urandom_range(8, 1));
            default: v = LenW'($urandom_range(60, 9));
        endcase
        return v;
    endfunction

    // Blank classes, control bytes, high bytes, case folding, text ends
    task automatic test_normalize_rules();
        logic [8:0] rules_seq [25];
        rules_seq = '{
            {1'b0, ChSpace}, {1'b0, ChTab},   {1'b0, 8'h41},   {1'b0, ChLf},
            {1'b0, 8'h01},   {1'b0, ChCr},    {1'b0, 8'h5A},   {1'b0, ChFf},
            {1'b0, 8'h00},   {1'b0, 8'h1F},   {1'b0, ChTilde}, {1'b0, 8'h7F},
            {1'b0, 8'h80},   {1'b0, 8'hFF},   {1'b0, 8'h40},   {1'b0, 8'h5B},
            {1'b0, ChSpace}, {1'b0, 8'h61},   {1'b0, ChSpace}, {1'b1, ChSpace},
            {1'b0, ChSpace}, {1'b0, 8'h71},   {1'b0, ChTab},   {1'b1, 8'h4D},
            {1'b1, 8'h05}
        };
        foreach (rules_seq[i]) begin
            send_byte(rules_seq[i][7:0], rules_seq[i][8]);
        end
    endtask

    // Zero, tiny and full buffers, and a capacity change inside a text
    task automatic test_capacity_limits();
        ready_mode <= ReadyPattern;
        write_capacity('0);
        send_text("Ab c", 1'b1);
        write_capacity(16'd1);
        send_text("Ab c", 1'b1);
        write_capacity(16'd2);
        send_text(" Ab c", 1'b1);
        write_capacity(16'd3);
        send_text(" x  y z", 1'b1);
        write_capacity(CapReset);
        send_text("Hello ", 1'b0);
        write_capacity(16'd4);
        send_text("World", 1'b1);
        write_capacity(16'd20);
        send_text("The  Quick brown FOX jumps over", 1'b1);
        write_capacity(CapReset);
    endtask

    task automatic test_random_texts();
        int unsigned start_count;
        int unsigned text_len;
        bit          closed;
        bit          noisy;
        start_count = items_sent;
        while (items_sent - start_count < RandomItems) begin
            ready_mode <= t_ready_mode'($urandom_range(3, 0));
            case ($urandom_range(3, 0))
                0:       gap_max = 0;
                1:       gap_max = 2;
                2:       gap_max = 6;
                default: gap_max = 12;
            endcase
            if ($urandom_range(4, 0) == 0) begin
                write_capacity(pick_capacity());
            end else if ($urandom_range(9, 0) == 0) begin
                drain_results();
            end
            // unterminated texts carry their state into the next one
            noisy    = ($urandom_range(4, 0) == 0);
            closed   = ($urandom_range(6, 0) != 0);
            text_len = noisy ? $urandom_range(20, 1) : $urandom_range(48, 1);
            for (int unsigned k = 0; k < text_len; k++) begin
                if (noisy) begin
                    send_byte(8'($urandom_range(8'hFF, 0)),
                              ($urandom_range(9, 0) == 0) || (closed && k == text_len - 1));
                end else begin
                    send_byte(text_byte(), closed && (k == text_len - 1));
                end
            end
        end
    endtask

    // Receiver stall pattern
    always @(posedge i_clk) begin
        ready_phase <= ready_phase + 1'b1;
        case (ready_mode)
            ReadyAlways:  m_axis_tready <= 1'b1;
            ReadyRandom:  m_axis_tready <= ($urandom_range(3, 0) != 0);
            ReadyPattern: m_axis_tready <= (ready_phase[2:0] != 3'd5) && (ready_phase != 4'd9);
            default:      m_axis_tready <= ($urandom_range(3, 0) == 0);
        endcase
    end

    // Compare each result word with the oldest pending one
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_words.size() == 0) begin
                report_mismatch("word with nothing pending", 0, 32'(m_axis_tdata));
            end else begin
                want = pending_words.pop_front();
                if (m_axis_tdata[6:0] !== want.ch) begin
                    report_mismatch("out_char", 32'(want.ch), 32'(m_axis_tdata[6:0]));
                end
                if (m_axis_tuser !== want.valid) begin
                    report_mismatch("char_valid", 32'(want.valid), 32'(m_axis_tuser));
                end
                if (m_axis_tlast !== want.eot) begin
                    report_mismatch("end_of_text", 32'(want.eot), 32'(m_axis_tlast));
                end
                if (m_axis_tdata[22:7] !== want.len) begin
                    report_mismatch("final_length", 32'(want.len), 32'(m_axis_tdata[22:7]));
                end
                if (m_axis_tdata[23] !== 1'b0) begin
                    report_mismatch("tdata pad bit", 0, 32'(m_axis_tdata[23]));
                end
            end
        end
    end

    // Watchdog: no word moving on any channel for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WatchdogLimit) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_normalize_rules();
        test_capacity_limits();
        test_random_texts();
        drain_results();
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/atn_pkg.sv
rtl/core/atn_core.sv
rtl/core/atn_out_queue.sv
rtl/core/ascii_text_normalizer.sv
dv/ascii_text_normalizer_tb.sv
